FILE: hdl/htbd_pkg.sv
// shared types, constants and the microcode rom of the huffman table bit decoder
// no dependencies; imported by the sequencer, datapath and top level of the block
package htbd_pkg;

  localparam int DEF_TABLE_DEPTH     = 256;
  localparam int DEF_MAX_CODE_LENGTH = 16;

  localparam int SYM_W      = 8;
  localparam int CODE_W     = 16;
  localparam int LEN_W      = 5;
  localparam int IDX_W      = 8;
  localparam int ENTRIES_W  = 9;
  localparam int COUNT_W    = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENTRIES_IN_USE   = 1'b0,
    REG_SYMBOLS_EXPECTED = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_DECODE = 1'b1
  } opcode_t;

  typedef struct packed {
    logic [SYM_W-1:0]  sym;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  // microprogram steps
  typedef enum logic [3:0] {
    ST_FETCH    = 4'd0,
    ST_DISPATCH = 4'd1,
    ST_CHECK    = 4'd2,
    ST_APPEND   = 4'd3,
    ST_SCAN     = 4'd4,
    ST_RESOLVE  = 4'd5,
    ST_EMIT     = 4'd6,
    ST_BACK     = 4'd7,
    ST_LOAD     = 4'd8
  } step_t;

  // jump conditions
  typedef enum logic [2:0] {
    COND_NEVER      = 3'd0,
    COND_ALWAYS     = 3'd1,
    COND_NO_WORD    = 3'd2,
    COND_IS_LOAD    = 3'd3,
    COND_COUNT_DONE = 3'd4,
    COND_SCAN_MORE  = 3'd5,
    COND_NO_RESULT  = 3'd6,
    COND_OUT_BUSY   = 3'd7
  } cond_t;

  typedef struct packed {
    logic  accept;
    logic  append;
    logic  scan_init;
    logic  scan;
    logic  emit;
    logic  write;
    cond_t cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic is_load;
    logic count_done;
    logic scan_more;
    logic no_result;
    logic out_busy;
  } stat_t;

  function automatic ctrl_t ucode_rom(step_t s);
    ctrl_t w;
    w        = '0;
    w.cond   = COND_ALWAYS;
    w.target = ST_FETCH;
    case (s)
      ST_FETCH: begin
        w.accept = 1'b1;
        w.cond   = COND_NO_WORD;
        w.target = ST_FETCH;
      end
      ST_DISPATCH: begin
        w.cond   = COND_IS_LOAD;
        w.target = ST_LOAD;
      end
      ST_CHECK: begin
        w.cond   = COND_COUNT_DONE;
        w.target = ST_FETCH;
      end
      ST_APPEND: begin
        w.append    = 1'b1;
        w.scan_init = 1'b1;
        w.cond      = COND_NEVER;
      end
      ST_SCAN: begin
        w.scan   = 1'b1;
        w.cond   = COND_SCAN_MORE;
        w.target = ST_SCAN;
      end
      ST_RESOLVE: begin
        w.cond   = COND_NO_RESULT;
        w.target = ST_FETCH;
      end
      ST_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = COND_OUT_BUSY;
        w.target = ST_EMIT;
      end
      ST_BACK: begin
        w.cond   = COND_ALWAYS;
        w.target = ST_FETCH;
      end
      ST_LOAD: begin
        w.write  = 1'b1;
        w.cond   = COND_ALWAYS;
        w.target = ST_FETCH;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = ST_FETCH;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: hdl/htbd_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module htbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/htbd_seq.sv
// microcode sequencer: step counter, control rom lookup and conditional jumps
// depends on htbd_pkg
module htbd_seq
  import htbd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  stat_t stat,
  output ctrl_t ctrl
);

  step_t step_r, step_nxt;
  logic  taken;

  // control word of the current step
  always_comb begin
    ctrl = ucode_rom(step_r);
  end

  // jump condition and next step
  always_comb begin
    case (ctrl.cond)
      COND_NEVER:      taken = 1'b0;
      COND_ALWAYS:     taken = 1'b1;
      COND_NO_WORD:    taken = !stat.in_valid;
      COND_IS_LOAD:    taken = stat.is_load;
      COND_COUNT_DONE: taken = stat.count_done;
      COND_SCAN_MORE:  taken = stat.scan_more;
      COND_NO_RESULT:  taken = stat.no_result;
      COND_OUT_BUSY:   taken = stat.out_busy;
      default:         taken = 1'b1;
    endcase
    step_nxt = taken ? ctrl.target : step_t'(step_r + 4'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_FETCH;
    end else begin
      step_r <= step_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_emit_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == ST_EMIT && !stat.out_busy) |=> step_r == ST_BACK)
    else $error("emit step did not finish with a free output register");

  a_load_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == ST_LOAD) |=> step_r == ST_FETCH)
    else $error("table row write did not return to fetch");

  a_scan_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == ST_SCAN && $past(step_r) != ST_SCAN) |-> $past(step_r) == ST_APPEND)
    else $error("scan entered without appending a bit");
`endif

endmodule

FILE: hdl/htbd_datapath.sv
// datapath: input latch, config registers, bit accumulator, row scan, output register
// depends on htbd_pkg; drives the table ram ports
module htbd_datapath
  import htbd_pkg::*;
#(
  parameter int TABLE_DEPTH     = DEF_TABLE_DEPTH,
  parameter int MAX_CODE_LENGTH = DEF_MAX_CODE_LENGTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ctrl_t                          ctrl,
  output stat_t                          stat,
  input  logic                           in_valid,
  input  logic                           in_opcode,
  input  logic [IDX_W-1:0]               in_row_index,
  input  logic [SYM_W-1:0]               in_row_symbol,
  input  logic [CODE_W-1:0]              in_row_code,
  input  logic [LEN_W-1:0]               in_row_length,
  input  logic                           in_code_bit,
  input  logic                           cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_DATA_W-1:0]          cfg_wdata,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [SYM_W-1:0]               out_symbol,
  output logic                           out_code_error,
  output logic                           out_final_symbol,
  output logic                           ram_we,
  output logic [$clog2(TABLE_DEPTH)-1:0] ram_waddr,
  output logic [ROW_W-1:0]               ram_wdata,
  output logic [$clog2(TABLE_DEPTH)-1:0] ram_raddr,
  input  logic [ROW_W-1:0]               ram_rdata
);

  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int PW   = $clog2(TABLE_DEPTH + 1);
  localparam int RW   = (PW > ENTRIES_W) ? PW : ENTRIES_W;
  localparam int IXW  = (PW > IDX_W) ? PW : IDX_W;
  localparam int ACW  = MAX_CODE_LENGTH;
  localparam int LW   = $clog2(MAX_CODE_LENGTH + 1);
  localparam int CMPW = (ACW > CODE_W) ? ACW : CODE_W;
  localparam int LCW  = (LW > LEN_W) ? LW : LEN_W;

  // latched input word
  opcode_t           op_r;
  logic [IDX_W-1:0]  idx_r;
  row_t              row_r;
  logic              bit_r;

  // config
  logic [ENTRIES_W-1:0] entries_r;
  logic [COUNT_W-1:0]   expected_r;

  // decode state
  logic [ACW-1:0]     acc_r, acc_nxt;
  logic [LW-1:0]      len_r, len_nxt;
  logic [COUNT_W-1:0] done_r, done_nxt;
  logic [PW-1:0]      ptr_r, ptr_nxt;
  logic               pend_r, pend_nxt;
  logic               matched_r, matched_nxt;
  logic [SYM_W-1:0]   hit_sym_r;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0]   out_symbol_r;
  logic               out_code_error_r;
  logic               out_final_r;

  logic [RW-1:0]  rows;
  logic [IXW-1:0] idx_x;
  logic           idx_ok;
  row_t           rd_row;
  logic           issue;
  logic           hit_now;
  logic           accepted;
  logic           out_busy;
  logic           emit_fire;

  assign accepted  = ctrl.accept && in_valid;
  assign out_busy  = out_valid_r && !out_ready;
  assign emit_fire = ctrl.emit && !out_busy;

  // rows searched, saturated at the table depth
  always_comb begin
    if (RW'(entries_r) > RW'(TABLE_DEPTH)) begin
      rows = RW'(TABLE_DEPTH);
    end else begin
      rows = RW'(entries_r);
    end
  end

  assign idx_x  = IXW'(idx_r);
  assign idx_ok = idx_x < IXW'(TABLE_DEPTH);

  // table ram
  assign ram_we    = ctrl.write && idx_ok;
  assign ram_waddr = idx_x[AW-1:0];
  assign ram_wdata = row_r;
  assign ram_raddr = ptr_r[AW-1:0];
  assign rd_row    = row_t'(ram_rdata);

  assign issue   = RW'(ptr_r) < rows;
  assign hit_now = pend_r
                && (LCW'(rd_row.len) == LCW'(len_r))
                && (CMPW'(rd_row.code) == CMPW'(acc_r));

  always_comb begin
    acc_nxt     = acc_r;
    len_nxt     = len_r;
    done_nxt    = done_r;
    ptr_nxt     = ptr_r;
    pend_nxt    = pend_r;
    matched_nxt = matched_r;
    if (ctrl.append) begin
      acc_nxt = {acc_r[ACW-2:0], bit_r};
      len_nxt = LW'(len_r + 1'b1);
    end
    if (ctrl.scan_init) begin
      ptr_nxt     = '0;
      pend_nxt    = 1'b0;
      matched_nxt = 1'b0;
    end
    if (ctrl.scan) begin
      pend_nxt = issue && !hit_now;
      if (issue) begin
        ptr_nxt = PW'(ptr_r + 1'b1);
      end
      if (hit_now) begin
        matched_nxt = 1'b1;
      end
    end
    if (emit_fire) begin
      acc_nxt = '0;
      len_nxt = '0;
      if (matched_r) begin
        done_nxt = COUNT_W'(done_r + 1'b1);
      end
    end
  end

  always_comb begin
    if (emit_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_comb begin
    stat.in_valid   = in_valid;
    stat.is_load    = (op_r == OP_LOAD);
    stat.count_done = done_r >= expected_r;
    stat.scan_more  = issue && !hit_now;
    stat.no_result  = !matched_r && (LW'(len_r) < LW'(MAX_CODE_LENGTH));
    stat.out_busy   = out_busy;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r   <= '0;
      expected_r  <= '0;
      acc_r       <= '0;
      len_r       <= '0;
      done_r      <= '0;
      ptr_r       <= '0;
      pend_r      <= 1'b0;
      matched_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_reg_t'(cfg_index))
          REG_ENTRIES_IN_USE:   entries_r  <= cfg_wdata[ENTRIES_W-1:0];
          REG_SYMBOLS_EXPECTED: expected_r <= cfg_wdata[COUNT_W-1:0];
          default: ;
        endcase
      end
      acc_r       <= acc_nxt;
      len_r       <= len_nxt;
      done_r      <= done_nxt;
      ptr_r       <= ptr_nxt;
      pend_r      <= pend_nxt;
      matched_r   <= matched_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accepted) begin
      op_r     <= opcode_t'(in_opcode);
      idx_r    <= in_row_index;
      row_r    <= '{sym: in_row_symbol, code: in_row_code, len: in_row_length};
      bit_r    <= in_code_bit;
    end
    if (ctrl.scan && hit_now) begin
      hit_sym_r <= rd_row.sym;
    end
    if (emit_fire) begin
      out_symbol_r     <= matched_r ? hit_sym_r : '0;
      out_code_error_r <= !matched_r;
      out_final_r      <= matched_r && (COUNT_W'(done_r + 1'b1) == expected_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_symbol       = out_symbol_r;
  assign out_code_error   = out_code_error_r;
  assign out_final_symbol = out_final_r;

`ifndef NO_ASSERTIONS
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    LW'(len_r) <= LW'(MAX_CODE_LENGTH))
    else $error("accumulated length above the longest code");

  a_acc_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_r >> len_r) == '0)
    else $error("accumulator holds bits above its length");

  a_error_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_code_error_r) |-> (out_symbol_r == '0 && !out_final_r))
    else $error("error word carries a symbol or final flag");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_fire && matched_r) |=> done_r == COUNT_W'($past(done_r) + 1'b1))
    else $error("symbol count did not advance on a decoded symbol");
`endif

endmodule

FILE: hdl/huffman_table_bit_decoder.sv
// top level of the huffman table bit decoder
// depends on htbd_pkg, htbd_ram, htbd_seq and htbd_datapath
//
// usage
//   input channel (in_valid/in_ready): one word per load or decode item;
//   in_opcode 0 writes table row in_row_index with symbol, code and length,
//   in_opcode 1 brings one stream bit in in_code_bit
//   output channel (out_valid/out_ready): one word per decoded symbol or
//   per overlong code; loads, unmatched bits and bits after the expected
//   symbol count give no word; config port: cfg_wr_en writes cfg_wdata
//   to register cfg_index (0 rows in use, 1 symbols expected); the user
//   does so only while the block is idle, which the block does not enforce
// steps
//   a load runs the fetch, dispatch and load steps; a decode bit runs
//   fetch, dispatch, check, append, a scan of the rows in use up to a hit,
//   resolve and, for a word, emit and back; past the symbol count it stops
//   at check; the emit step loads the result word into the output register
// reset
//   synchronous, active low; clears the accumulator, symbol count and both
//   config registers; the table ram keeps its contents and needs loading
// stall
//   the output word is registered; a new item is taken while it waits,
//   and the sequencer holds in its emit step until the register is free
module huffman_table_bit_decoder
  import htbd_pkg::*;
#(
  parameter int TABLE_DEPTH     = DEF_TABLE_DEPTH,
  parameter int MAX_CODE_LENGTH = DEF_MAX_CODE_LENGTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_opcode,
  input  logic [IDX_W-1:0]      in_row_index,
  input  logic [SYM_W-1:0]      in_row_symbol,
  input  logic [CODE_W-1:0]     in_row_code,
  input  logic [LEN_W-1:0]      in_row_length,
  input  logic                  in_code_bit,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SYM_W-1:0]      out_symbol,
  output logic                  out_code_error,
  output logic                  out_final_symbol,
  // config port
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(TABLE_DEPTH);

  ctrl_t ctrl;
  stat_t stat;

  // table ram port signals
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [ROW_W-1:0] ram_wdata;
  logic [ROW_W-1:0] ram_rdata;

  // the fetch step of the microprogram opens the input channel
  assign in_ready = ctrl.accept;

  // microcode sequencer: one control word per step
  htbd_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  // accumulator, row scan and output register
  htbd_datapath #(
    .TABLE_DEPTH     (TABLE_DEPTH),
    .MAX_CODE_LENGTH (MAX_CODE_LENGTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctrl             (ctrl),
    .stat             (stat),
    .in_valid         (in_valid),
    .in_opcode        (in_opcode),
    .in_row_index     (in_row_index),
    .in_row_symbol    (in_row_symbol),
    .in_row_code      (in_row_code),
    .in_row_length    (in_row_length),
    .in_code_bit      (in_code_bit),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_symbol       (out_symbol),
    .out_code_error   (out_code_error),
    .out_final_symbol (out_final_symbol),
    .ram_we           (ram_we),
    .ram_waddr        (ram_waddr),
    .ram_wdata        (ram_wdata),
    .ram_raddr        (ram_raddr),
    .ram_rdata        (ram_rdata)
  );

  // code table: symbol, code and length packed in one row
  htbd_ram #(
    .WIDTH (ROW_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

FILE: dv/huffman_table_bit_decoder_test.sv
// self-checking testbench of the huffman table bit decoder: table loads and code bit streams
// depends on htbd_pkg and the huffman_table_bit_decoder rtl; reads no files
`timescale 1ns / 100ps

module huffman_table_bit_decoder_test;
  import htbd_pkg::*;

  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int DRAIN_CYCLES = DEF_TABLE_DEPTH + 64;
  localparam int ITEM_TARGET  = 2000;

  // one result word of the block
  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             err;
    logic             fin;
  } decoded_t;

  // receiver stall styles
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_LONG
  } rx_mode_t;

  // tracks table, accumulator and symbol count; holds the words still owed by the block
  class decode_checker;
    bit [SYM_W-1:0]     tab_sym[DEF_TABLE_DEPTH];
    bit [CODE_W-1:0]    tab_code[DEF_TABLE_DEPTH];
    bit [LEN_W-1:0]     tab_len[DEF_TABLE_DEPTH];
    bit [CODE_W-1:0]    acc;
    int unsigned        acc_len;
    bit [COUNT_W-1:0]   done_count;
    bit [ENTRIES_W-1:0] rows_in_use;
    bit [COUNT_W-1:0]   count_target;
    decoded_t           symbols_due[$];
    int unsigned        mismatches, n_loads, n_bits, n_ignored, n_symbols, n_overlong;

    function int pending();
      return symbols_due.size();
    endfunction

    // returns 0 when the block just drops the word
    function bit note_word(opcode_t op, bit [IDX_W-1:0] idx, bit [SYM_W-1:0] sym,
                           bit [CODE_W-1:0] code, bit [LEN_W-1:0] len, bit cbit);
      decoded_t    w;
      int unsigned rows;
      int unsigned r;
      if (op == OP_LOAD) begin
        tab_sym[idx]  = sym;
        tab_code[idx] = code;
        tab_len[idx]  = len;
        n_loads++;
        return 1'b1;
      end
      if (done_count >= count_target) begin
        n_ignored++;
        return 1'b0;
      end
      n_bits++;
      acc = {acc[CODE_W-2:0], cbit};
      acc_len++;
      rows = (rows_in_use > DEF_TABLE_DEPTH) ? DEF_TABLE_DEPTH : rows_in_use;
      // lowest matching row wins
      for (r = 0; r < rows; r++) begin
        if (tab_len[r] == acc_len && tab_code[r] == acc) begin
          acc        = '0;
          acc_len    = 0;
          done_count = done_count + 1;
          w.sym      = tab_sym[r];
          w.err      = 1'b0;
          w.fin      = (done_count == count_target);
          symbols_due.push_back(w);
          n_symbols++;
          return 1'b1;
        end
      end
      if (acc_len >= DEF_MAX_CODE_LENGTH) begin
        acc     = '0;
        acc_len = 0;
        w.sym   = '0;
        w.err   = 1'b1;
        w.fin   = 1'b0;
        symbols_due.push_back(w);
        n_overlong++;
      end
      return 1'b1;
    endfunction

    task report(string msg);
      if (mismatches < 40)
        $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_word(logic [SYM_W-1:0] sym, logic err, logic fin);
      decoded_t w;
      if (symbols_due.size() == 0) begin
        report($sformatf("unexpected word sym %02h err %b final %b", sym, err, fin));
        return;
      end
      w = symbols_due.pop_front();
      if (sym !== w.sym)
        report($sformatf("symbol %02h, want %02h", sym, w.sym));
      if (err !== w.err)
        report($sformatf("code_error %b, want %b", err, w.err));
      if (fin !== w.fin)
        report($sformatf("final_symbol %b, want %b", fin, w.fin));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_opcode = 1'b0;
  logic [IDX_W-1:0]      in_row_index = '0;
  logic [SYM_W-1:0]      in_row_symbol = '0;
  logic [CODE_W-1:0]     in_row_code = '0;
  logic [LEN_W-1:0]      in_row_length = '0;
  logic                  in_code_bit = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [SYM_W-1:0]      out_symbol;
  logic                  out_code_error;
  logic                  out_final_symbol;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  decode_checker sb;
  int unsigned   cycle_count = 0;
  int            burst_left = 0;
  int            live_items = 0;
  int            n_settings = 0;
  bit            loaded[DEF_TABLE_DEPTH];

  // prefix code under construction: one leaf per symbol
  bit [CODE_W-1:0] leaf_code[$];
  int              leaf_len[$];

  rx_mode_t rx_mode = RX_OPEN;
  int       rx_mode_left = 0;
  int       rx_hold = 0;

  huffman_table_bit_decoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_row_index     (in_row_index),
    .in_row_symbol    (in_row_symbol),
    .in_row_code      (in_row_code),
    .in_row_length    (in_row_length),
    .in_code_bit      (in_code_bit),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_symbol       (out_symbol),
    .out_code_error   (out_code_error),
    .out_final_symbol (out_final_symbol),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #10 clk = ~clk;

  // watchdog: a hung block ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: the stall style is picked at random for each stretch, open stretches included
  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      <= rx_mode_t'($urandom_range(0, 2));
      rx_mode_left <= $urandom_range(100, 600);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    case (rx_mode)
      RX_OPEN: out_ready <= 1'b1;
      RX_COIN: out_ready <= 1'($urandom_range(0, 1));
      default: begin
        // long runs of ready and stall, each of random length
        if (rx_hold == 0) begin
          out_ready <= ~out_ready;
          rx_hold   <= $urandom_range(1, 40);
        end else begin
          rx_hold <= rx_hold - 1;
        end
      end
    endcase
  end

  // every accepted result word is checked against the oldest one owed
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_word(out_symbol, out_code_error, out_final_symbol);
  end

  // one input word; the sender idles between bursts of random length
  task automatic send_word(opcode_t op, bit [IDX_W-1:0] idx, bit [SYM_W-1:0] sym,
                           bit [CODE_W-1:0] code, bit [LEN_W-1:0] len, bit cbit);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      // now and then a long burst with no idle cycles at all
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_row_index  <= idx;
    in_row_symbol <= sym;
    in_row_code   <= code;
    in_row_length <= len;
    in_code_bit   <= cbit;
    do @(posedge clk); while (!in_ready);
    if (sb.note_word(op, idx, sym, code, len, cbit))
      live_items++;
  endtask

  task automatic load_row(bit [IDX_W-1:0] idx, bit [SYM_W-1:0] sym,
                          bit [CODE_W-1:0] code, bit [LEN_W-1:0] len);
    loaded[idx] = 1'b1;
    send_word(OP_LOAD, idx, sym, code, len, 1'($urandom_range(0, 1)));
  endtask

  // row fields of a decode word are don't care, so they get noise
  task automatic decode_bit(bit cbit);
    send_word(OP_DECODE, IDX_W'($urandom), SYM_W'($urandom), CODE_W'($urandom),
              LEN_W'($urandom), cbit);
  endtask

  // sender stops until every owed result word is out
  task automatic hold_for_results();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // idle point: also covers the scan of a trailing bit that gives no word
  task automatic settle();
    hold_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // both registers, back to back; junk above the 9 bit row count
  task automatic set_config(bit [ENTRIES_W-1:0] rows, bit [COUNT_W-1:0] target);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_ENTRIES_IN_USE;
    cfg_wdata <= {(CFG_DATA_W - ENTRIES_W)'($urandom), rows};
    @(posedge clk);
    sb.rows_in_use = rows;
    cfg_index <= REG_SYMBOLS_EXPECTED;
    cfg_wdata <= target;
    @(posedge clk);
    sb.count_target = target;
    cfg_wr_en <= 1'b0;
    n_settings++;
  endtask

  // rows 0.. that were all written at least once
  function automatic int loaded_prefix();
    int i;
    i = 0;
    while (i < DEF_TABLE_DEPTH && loaded[i])
      i++;
    return i;
  endfunction

  // complete prefix code with k leaves: split random leaves, no deeper than the max length
  function automatic void build_code(int k);
    int              i;
    bit [CODE_W-1:0] c;
    int              l;
    leaf_code.delete();
    leaf_len.delete();
    leaf_code.push_back(CODE_W'(0));
    leaf_len.push_back(1);
    leaf_code.push_back(CODE_W'(1));
    leaf_len.push_back(1);
    while (leaf_code.size() < k) begin
      i = $urandom_range(0, leaf_code.size() - 1);
      if (leaf_len[i] < DEF_MAX_CODE_LENGTH) begin
        c = leaf_code[i];
        l = leaf_len[i];
        leaf_code.delete(i);
        leaf_len.delete(i);
        leaf_code.push_back({c[CODE_W-2:0], 1'b0});
        leaf_len.push_back(l + 1);
        leaf_code.push_back({c[CODE_W-2:0], 1'b1});
        leaf_len.push_back(l + 1);
      end
    end
  endfunction

  // one random phase: new table, new settings, then a coded bit stream
  // phase 1 fills the whole table and sets a row count past its end,
  // phase 2 searches no rows, phase 3 asks for no symbols at all
  task automatic run_phase(int p);
    int               k, n, pre, rows, nsym, tail, j, b, pick;
    bit [SYM_W-1:0]   rsym[$];
    bit [CODE_W-1:0]  rcode[$];
    bit [LEN_W-1:0]   rlen[$];
    bit [COUNT_W-1:0] target;
    if (p == 1)
      k = DEF_TABLE_DEPTH;
    else if ($urandom_range(0, 7) == 0)
      k = $urandom_range(17, 64);
    else
      k = $urandom_range(2, 16);
    build_code(k);
    for (j = 0; j < k; j++) begin
      rsym.push_back(SYM_W'($urandom));
      rcode.push_back(leaf_code[j]);
      rlen.push_back(LEN_W'(leaf_len[j]));
    end
    // spoil one row now and then: its code becomes dead and ends in overlong errors
    if (p > 3 && $urandom_range(0, 3) == 0) begin
      j = $urandom_range(0, k - 1);
      case ($urandom_range(0, 2))
        0: begin
          // stray bit above the length
          if (rlen[j] < CODE_W)
            rcode[j][$urandom_range(rlen[j], CODE_W - 1)] = 1'b1;
          else
            rlen[j] = '0;
        end
        1: rlen[j] = '0;
        default: rlen[j] = LEN_W'($urandom_range(DEF_MAX_CODE_LENGTH + 1, 31));
      endcase
    end
    // same code again in a higher row, under another symbol: the lower row must win
    if (k < DEF_TABLE_DEPTH && $urandom_range(0, 3) == 0) begin
      j = $urandom_range(0, k - 1);
      rsym.push_back(~rsym[j]);
      rcode.push_back(rcode[j]);
      rlen.push_back(rlen[j]);
    end
    n = rsym.size();
    for (j = 0; j < n; j++)
      load_row(IDX_W'(j), rsym[j], rcode[j], rlen[j]);
    settle();

    // searched rows never reach a row that was never written
    pre = loaded_prefix();
    if (p == 1) begin
      rows = ($urandom_range(0, 1) == 0) ? 511 : $urandom_range(DEF_TABLE_DEPTH, 511);
    end else if (p == 2) begin
      rows = 0;
    end else begin
      case ($urandom_range(0, 9))
        0: rows = 0;
        1: rows = $urandom_range(1, n);
        2: rows = n + $urandom_range(0, 16);
        default: rows = n;
      endcase
    end
    if (pre < DEF_TABLE_DEPTH && rows > pre)
      rows = pre;

    if (p == 1) begin
      target = '1;
    end else if (p == 3) begin
      target = '0;
    end else begin
      case ($urandom_range(0, 9))
        0: target = '1;
        1: target = sb.done_count;
        default: target = sb.done_count + COUNT_W'($urandom_range(1, 40));
      endcase
    end
    set_config(ENTRIES_W'(rows), target);

    if (p == 1)
      nsym = 8;
    else if (p == 2)
      nsym = 20;
    else if (p == 3)
      nsym = 2;
    else
      nsym = $urandom_range(4, 40);
    // a few symbols past the count, then stop since the rest would be dropped
    tail = 0;
    for (j = 0; j < nsym && tail < 3; j++) begin
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 20)) decode_bit(1'($urandom_range(0, 1)));
      if ($urandom_range(0, 29) == 0) begin
        // table rewrite in the middle of a stream
        pre = loaded_prefix();
        load_row(IDX_W'($urandom_range(0, (pre < DEF_TABLE_DEPTH) ? pre : DEF_TABLE_DEPTH - 1)),
                 SYM_W'($urandom), CODE_W'($urandom), LEN_W'($urandom));
      end
      if ($urandom_range(0, 49) == 0)
        hold_for_results();
      pick = $urandom_range(0, k - 1);
      for (b = leaf_len[pick] - 1; b >= 0; b--)
        decode_bit(leaf_code[pick][b]);
      if (sb.done_count >= sb.count_target)
        tail++;
    end
  endtask

  initial begin
    int p;
    int start_items;
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: six rows, three symbols wanted
    set_config(ENTRIES_W'(6), COUNT_W'(3));
    load_row(IDX_W'(0), 8'h00, 16'h0000, 5'd1);   // "0"
    load_row(IDX_W'(1), 8'hff, 16'hffff, 5'd16);  // sixteen ones, longest code
    load_row(IDX_W'(2), 8'h22, 16'h8002, 5'd2);   // "10" with a stray high bit, dead
    load_row(IDX_W'(3), 8'h33, 16'h0000, 5'd0);   // zero length, dead
    load_row(IDX_W'(4), 8'h44, 16'h7fff, 5'd31);  // length beyond the max, dead
    load_row(IDX_W'(5), 8'haa, 16'h0002, 5'd2);   // "10", found past the dead row
    decode_bit(1'b0);
    decode_bit(1'b1);
    decode_bit(1'b0);
    // fifteen ones pass the dead row 4 code without a hit, sixteenth ends the count
    repeat (16) decode_bit(1'b1);
    // count reached, dropped
    decode_bit(1'b1);
    settle();

    start_items = live_items;
    p = 1;
    while (live_items - start_items < ITEM_TARGET) begin
      run_phase(p);
      p++;
    end
    settle();

    $display("covered %0d table loads, %0d decode bits and %0d dropped bits in %0d settings",
             sb.n_loads, sb.n_bits, sb.n_ignored, n_settings);
    $display("checked %0d symbols and %0d overlong codes, %0d mismatches",
             sb.n_symbols, sb.n_overlong, sb.mismatches);
    if (sb.mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: sim.f
hdl/htbd_pkg.sv
hdl/htbd_ram.sv
hdl/htbd_seq.sv
hdl/htbd_datapath.sv
hdl/huffman_table_bit_decoder.sv
dv/huffman_table_bit_decoder_test.sv
